### rtl/core/rci_pkg.sv
// Shared types and constants for the row/column byte interleaver.
// No dependencies; compiled first.
`default_nettype none

package rci_pkg;

   // Width of the row count register
   localparam int unsigned RCW = 13;

   // Request operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED  = 2'd0,
      STATUS_DROPPED   = 2'd1,
      STATUS_DELIVERED = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RESP = 2'd1,
      ST_DIV  = 2'd2
   } state_type;

endpackage

`default_nettype wire

### rtl/core/rci_channels.sv
// Valid/ready channel interfaces for the interleaver: request, response, csr.
// Depends on rci_pkg.
`default_nettype none

interface rci_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;
   logic       end_of_block;

   modport source (output valid, output op, output data_byte, output end_of_block,
                   input ready);
   modport sink   (input valid, input op, input data_byte, input end_of_block,
                   output ready);
endinterface

interface rci_rsp_if;
   logic                valid;
   logic                ready;
   rci_pkg::status_type status;
   logic [7:0]          out_byte;
   logic                out_last;

   modport source (output valid, output status, output out_byte, output out_last,
                   input ready);
   modport sink   (input valid, input status, input out_byte, input out_last,
                   output ready);
endinterface

interface rci_csr_if;
   logic                    valid;
   logic                    ready;
   logic [rci_pkg::RCW-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/row_column_byte_interleaver.sv
// Row/column byte interleaver: the response word of a push or a pull is registered
// once the response register is free or being taken by the receiver;
// no new word is accepted until that response is loaded, set by the request/response sequencer.
// The push that closes a block holds off the next word while the shared restoring
// divider forms row length and tail count, one bit a cycle.
// Reset is synchronous: control, counters and row count (to 1) clear at once;
// the byte store is not cleared and needs no clearing pass.
`default_nettype none

module row_column_byte_interleaver #(
   parameter int unsigned MAX_BYTES = 4096
) (
   input  wire logic clock,
   input  wire logic reset,
   rci_req_if.sink   req_bus,
   rci_rsp_if.source rsp_bus,
   rci_csr_if.sink   csr_bus
);

   localparam int unsigned RCW = rci_pkg::RCW;
   localparam int unsigned AW  = $clog2(MAX_BYTES);
   localparam int unsigned CW  = $clog2(MAX_BYTES + 1);
   localparam int unsigned SW  = ((CW > RCW) ? CW : RCW) + 1;

   rci_pkg::state_type  state_ff, state_in;

   logic [RCW-1:0]      row_count_ff;
   logic [RCW-1:0]      rows_latched_ff, rows_latched_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [CW-1:0]       row_len_ff, row_len_in;
   logic [CW-1:0]       tail_ff, tail_in;
   logic                draining_ff, draining_in;
   logic [CW-1:0]       cursor_ff, cursor_in;
   logic [RCW-1:0]      row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [CW-1:0]       src_ff, src_in;
   rci_pkg::status_type pend_status_ff, pend_status_in;
   logic                pend_last_ff, pend_last_in;
   logic                close_pend_ff, close_pend_in;

   logic                rsp_valid_ff;
   rci_pkg::status_type rsp_status_ff;
   logic [7:0]          rsp_byte_ff;
   logic                rsp_last_ff;

   logic [7:0]          mem [MAX_BYTES];
   logic [7:0]          mem_rd_ff;

   logic                req_ready;
   logic                rsp_load;
   logic                div_start;
   logic                div_done;
   logic [CW-1:0]       div_quo;
   logic [RCW-1:0]      div_rem;

   logic                acc;
   logic                push_ok;
   logic [CW-1:0]       fill_after;
   logic                close_now;
   logic [CW-1:0]       body;
   logic                in_body;
   logic [CW-1:0]       rd_addr;
   logic [CW:0]         col_inc;
   logic                row_end;
   logic [CW:0]         cursor_inc;
   logic                last_now;
   logic [SW-1:0]       src_step;
   logic [RCW:0]        row_inc;

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         rci_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         rci_pkg::ST_RESP: begin
            rsp_load  = !rsp_valid_ff || rsp_bus.ready;
            div_start = rsp_load && close_pend_ff;
         end
         rci_pkg::ST_DIV: begin
         end
         default: begin
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rci_pkg::ST_IDLE: begin
            if (acc) state_in = rci_pkg::ST_RESP;
         end
         rci_pkg::ST_RESP: begin
            if (rsp_load) state_in = close_pend_ff ? rci_pkg::ST_DIV : rci_pkg::ST_IDLE;
         end
         rci_pkg::ST_DIV: begin
            if (div_done) state_in = rci_pkg::ST_IDLE;
         end
         default: begin
            state_in = rci_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath for the accepted word
   always_comb begin
      acc        = req_bus.valid && req_ready;
      push_ok    = !draining_ff && (fill_ff < CW'(MAX_BYTES));
      fill_after = push_ok ? fill_ff + CW'(1) : fill_ff;
      close_now  = !draining_ff && req_bus.end_of_block && (fill_after != '0);
      body       = fill_ff - tail_ff;
      in_body    = cursor_ff < body;
      rd_addr    = in_body ? src_ff : cursor_ff;
      col_inc    = {1'b0, col_ff} + (CW+1)'(1);
      row_end    = col_inc >= {1'b0, row_len_ff};
      cursor_inc = {1'b0, cursor_ff} + (CW+1)'(1);
      last_now   = cursor_inc >= {1'b0, fill_ff};
      src_step   = SW'(src_ff) + SW'(rows_latched_ff);
      row_inc    = {1'b0, row_ff} + (RCW+1)'(1);
   end

   always_comb begin
      rows_latched_in = rows_latched_ff;
      fill_in         = fill_ff;
      row_len_in      = row_len_ff;
      tail_in         = tail_ff;
      draining_in     = draining_ff;
      cursor_in       = cursor_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      src_in          = src_ff;
      pend_status_in  = pend_status_ff;
      pend_last_in    = pend_last_ff;
      close_pend_in   = close_pend_ff;
      if (acc) begin
         pend_last_in  = 1'b0;
         close_pend_in = 1'b0;
         if (req_bus.op == rci_pkg::OP_PUSH) begin
            fill_in        = fill_after;
            pend_status_in = push_ok ? rci_pkg::STATUS_ACCEPTED : rci_pkg::STATUS_DROPPED;
            if (close_now) begin
               close_pend_in   = 1'b1;
               rows_latched_in = (row_count_ff == '0) ? RCW'(1) : row_count_ff;
            end
         end else if (!draining_ff) begin
            pend_status_in = rci_pkg::STATUS_EMPTY;
         end else begin
            pend_status_in = rci_pkg::STATUS_DELIVERED;
            if (in_body) begin
               // walk down the column; jump to the head of the next row at its end
               if (row_end) begin
                  col_in = '0;
                  row_in = RCW'(row_inc);
                  src_in = CW'(row_inc);
               end else begin
                  col_in = CW'(col_inc);
                  src_in = CW'(src_step);
               end
            end
            cursor_in = CW'(cursor_inc);
            if (last_now) begin
               pend_last_in = 1'b1;
               fill_in      = '0;
               row_len_in   = '0;
               tail_in      = '0;
               draining_in  = 1'b0;
               cursor_in    = '0;
               row_in       = '0;
               col_in       = '0;
               src_in       = '0;
            end
         end
      end
      if (div_done) begin
         row_len_in  = div_quo;
         tail_in     = CW'(div_rem);
         draining_in = 1'b1;
         cursor_in   = '0;
         row_in      = '0;
         col_in      = '0;
         src_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= rci_pkg::ST_IDLE;
         row_count_ff    <= RCW'(1);
         rows_latched_ff <= RCW'(1);
         fill_ff         <= '0;
         row_len_ff      <= '0;
         tail_ff         <= '0;
         draining_ff     <= 1'b0;
         cursor_ff       <= '0;
         row_ff          <= '0;
         col_ff          <= '0;
         src_ff          <= '0;
         close_pend_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rows_latched_ff <= rows_latched_in;
         fill_ff         <= fill_in;
         row_len_ff      <= row_len_in;
         tail_ff         <= tail_in;
         draining_ff     <= draining_in;
         cursor_ff       <= cursor_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
         src_ff          <= src_in;
         close_pend_ff   <= close_pend_in;
         if (csr_bus.valid) row_count_ff <= csr_bus.data;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // pending and response word payload
   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_last_ff   <= pend_last_in;
      if (rsp_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_byte_ff   <= (pend_status_ff == rci_pkg::STATUS_DELIVERED) ? mem_rd_ff : 8'd0;
         rsp_last_ff   <= pend_last_ff;
      end
   end

   // byte store: at most one write or one registered read per accepted word
   always_ff @(posedge clock) begin
      if (acc && (req_bus.op == rci_pkg::OP_PUSH) && push_ok)
         mem[fill_ff[AW-1:0]] <= req_bus.data_byte;
      if (acc && (req_bus.op == rci_pkg::OP_PULL) && draining_ff)
         mem_rd_ff <= mem[rd_addr[AW-1:0]];
   end

   rci_divider #(
      .DW (CW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (fill_ff),
      .divisor   (rows_latched_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_bus.ready    = req_ready;
   assign csr_bus.ready    = 1'b1;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.status   = rsp_status_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;
   assign rsp_bus.out_last = rsp_last_ff;

   a_drain_has_bytes: assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> (fill_ff != '0) && (cursor_ff < fill_ff))
      else $error("draining with no bytes left");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      acc |=> !req_bus.ready)
      else $error("word accepted while previous word in progress");

   a_div_only_loading: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rci_pkg::ST_DIV) |-> !draining_ff)
      else $error("divider running while block drains");

   a_last_is_delivery: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_status_ff == rci_pkg::STATUS_DELIVERED))
      else $error("last flag on a non-delivery response");

   a_last_ends_block: assert property (@(posedge clock) disable iff (reset)
      (acc && pend_last_in) |=> !draining_ff && (fill_ff == '0))
      else $error("final byte did not reopen loading");

endmodule

`default_nettype wire

### rtl/core/rci_divider.sv
// Restoring divider, one quotient bit per cycle, for row length and tail count.
// Depends on rci_pkg for the divisor width.
`default_nettype none

module rci_divider #(
   parameter int unsigned DW = 13
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [DW-1:0]           dividend,
   input  wire logic [rci_pkg::RCW-1:0] divisor,
   output logic                         done,
   output logic [DW-1:0]                quotient,
   output logic [rci_pkg::RCW-1:0]      remainder
);

   localparam int unsigned RCW  = rci_pkg::RCW;
   localparam int unsigned CNTW = $clog2(DW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [RCW-1:0]  rem_ff, rem_in;
   logic [RCW:0]    trial;
   logic            ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      ge      = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         quo_in = {quo_ff[DW-2:0], ge};
         rem_in = ge ? RCW'(trial - {1'b0, divisor}) : RCW'(trial);
         cnt_in = cnt_ff + CNTW'(1);
         if (cnt_ff == CNTW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished run");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && divisor != '0) |=> ($past(start) || rem_ff < divisor))
      else $error("divider remainder not reduced");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider failed to start");

endmodule

`default_nettype wire
